### rtl/rpa_pkg.sv
// Shared constants, command and status codes, and controller states of the page allocator.
package rpa_pkg;

   localparam int NUM_PAGES_DEF = 1024;
   localparam int SHARERS_DEF   = 64;

   localparam int PAGE_W  = 10;
   localparam int COUNT_W = 8;
   localparam int TAG_W   = 32;
   localparam int SLOT_W  = 6;
   localparam int MODE_W  = 4;
   localparam int STAT_W  = 3;
   localparam int FREE_W  = 11;

   localparam logic [MODE_W-1:0] MODE_ALLOC     = 4'd0;
   localparam logic [MODE_W-1:0] MODE_FREE      = 4'd1;
   localparam logic [MODE_W-1:0] MODE_INCREF    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_SETREF    = 4'd3;
   localparam logic [MODE_W-1:0] MODE_READREF   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_ADDSHR    = 4'd5;
   localparam logic [MODE_W-1:0] MODE_REMOVESHR = 4'd6;
   localparam logic [MODE_W-1:0] MODE_READSLOT  = 4'd7;
   localparam logic [MODE_W-1:0] MODE_WRITESLOT = 4'd8;

   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd4;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_POP_WAIT,
      S_WIPE,
      S_REF_WAIT,
      S_SCAN,
      S_ADD_FIN,
      S_SLOT_WAIT,
      S_RESP
   } state_type;

endpackage

### rtl/refcounted_page_allocator_unit.sv
// Top level of the reference-counted page allocator: command sequencer and its three memories.
//
// Commands arrive one at a time on the req_ channel and each yields exactly one result on
// the rsp_ channel. Free pages sit on a LIFO stack in one memory, reference counts in a
// second, and sharer tags (SHARERS slots per page) in a third. Alloc, add sharer and
// remove sharer walk all sharer slots of the page, one slot per cycle through the single
// sharer memory port; range errors, alloc on an empty stack, and count and slot commands
// do not. A finished command waits in its result state while the previous result still
// waits on rsp_. A new command is taken while the previous result still waits on rsp_.
// After reset the block sweeps every entry of the count and sharer memories to zero,
// with req_tready low; csr_ writes are taken at any time.
module refcounted_page_allocator_unit #(
   parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF,
   parameter int SHARERS   = rpa_pkg::SHARERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[3:0], page[13:4], count_value[21:14], sharer_tag[53:22], slot[59:54], zero pad
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], page_out[12:3], ref_count[20:13], free_pages[31:21], sharer_out[63:32]
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data
);
   import rpa_pkg::*;

   localparam int PAGE_AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int SLOT_AW = (SHARERS > 1) ? $clog2(SHARERS) : 1;
   localparam int SH_AW   = PAGE_AW + SLOT_AW;
   localparam int FCNT_W  = $clog2(NUM_PAGES + 1);
   localparam int SCNT_W  = $clog2(SHARERS + 1);
   localparam logic [16:0]       NP_L     = 17'(NUM_PAGES);
   localparam logic [SLOT_W:0]   SH_L     = (SLOT_W + 1)'(SHARERS);
   localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(SHARERS - 1);

   state_type state_ff, state_in;

   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [COUNT_W-1:0] cval_ff, cval_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [STAT_W-1:0]  st_ff, st_in;
   logic [COUNT_W-1:0] rc_ff, rc_in;
   logic [TAG_W-1:0]   sout_ff, sout_in;
   logic [FCNT_W-1:0]  fcnt_ff, fcnt_in;
   logic [PAGE_W-1:0]  first_ff, first_in;
   logic [SH_AW-1:0]   clr_ff, clr_in;
   logic [SCNT_W-1:0]  iss_ff, iss_in;
   logic               dv_ff, dv_in;
   logic [SLOT_AW-1:0] didx_ff, didx_in;
   logic               found_ff, found_in;
   logic               present_ff, present_in;
   logic [SLOT_AW-1:0] at_ff, at_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   // memory ports
   logic               stk_we;
   logic [PAGE_AW-1:0] stk_waddr, stk_raddr;
   logic [PAGE_W-1:0]  stk_wdata, stk_rdata;
   logic               ref_we;
   logic [PAGE_AW-1:0] ref_waddr, ref_raddr;
   logic [COUNT_W-1:0] ref_wdata, ref_rdata;
   logic               sh_we;
   logic [SH_AW-1:0]   sh_waddr, sh_raddr;
   logic [TAG_W-1:0]   sh_wdata, sh_rdata;

   logic [PAGE_AW+PAGE_W-1:0] page_ext, pop_ext;
   logic [PAGE_AW-1:0]        pa, pop_pa;
   logic [FCNT_W+FREE_W-1:0]  fcnt_ext;
   logic [FCNT_W-1:0]         fcnt_dec;
   logic                      in_range, slot_ok, load_rsp;
   logic [COUNT_W-1:0]        nc;

   assign page_ext = {{PAGE_AW{1'b0}}, page_ff};
   assign pa       = page_ext[PAGE_AW-1:0];
   assign pop_ext  = {{PAGE_AW{1'b0}}, stk_rdata};
   assign pop_pa   = pop_ext[PAGE_AW-1:0];
   assign fcnt_ext = {{FREE_W{1'b0}}, fcnt_ff};
   assign fcnt_dec = fcnt_ff - FCNT_W'(1);
   assign in_range = (page_ff >= first_ff) && ({7'd0, page_ff} < NP_L);
   assign slot_ok  = {1'b0, slot_ff} < SH_L;
   assign load_rsp = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      page_in    = page_ff;
      cval_in    = cval_ff;
      tag_in     = tag_ff;
      slot_in    = slot_ff;
      st_in      = st_ff;
      rc_in      = rc_ff;
      sout_in    = sout_ff;
      fcnt_in    = fcnt_ff;
      first_in   = (csr_valid) ? csr_data : first_ff;
      clr_in     = clr_ff;
      iss_in     = iss_ff;
      dv_in      = 1'b0;
      didx_in    = didx_ff;
      found_in   = found_ff;
      present_in = present_ff;
      at_in      = at_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      nc         = '0;

      stk_we    = 1'b0;
      stk_waddr = fcnt_ff[PAGE_AW-1:0];
      stk_wdata = page_ff;
      stk_raddr = fcnt_dec[PAGE_AW-1:0];
      ref_we    = 1'b0;
      ref_waddr = pa;
      ref_wdata = '0;
      ref_raddr = pa;
      sh_we     = 1'b0;
      sh_waddr  = {pa, didx_ff};
      sh_wdata  = '0;
      sh_raddr  = {pa, iss_ff[SLOT_AW-1:0]};

      unique case (state_ff)
         S_CLEAR: begin
            // zero one sharer slot and its page's count per cycle
            sh_we     = 1'b1;
            sh_waddr  = clr_ff;
            ref_we    = 1'b1;
            ref_waddr = clr_ff[SH_AW-1 -: PAGE_AW];
            clr_in    = clr_ff + SH_AW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tdata[3:0];
               page_in  = req_tdata[13:4];
               cval_in  = req_tdata[21:14];
               tag_in   = req_tdata[53:22];
               slot_in  = req_tdata[59:54];
               st_in    = STAT_OK;
               rc_in    = '0;
               sout_in  = '0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            iss_in     = '0;
            found_in   = 1'b0;
            present_in = 1'b0;
            if (mode_ff == MODE_ALLOC) begin
               if (fcnt_ff == '0) begin
                  st_in    = STAT_EMPTY;
                  page_in  = '0;
                  state_in = S_RESP;
               end else begin
                  fcnt_in  = fcnt_dec;
                  state_in = S_POP_WAIT;
               end
            end else if (!in_range) begin
               if (mode_ff <= MODE_WRITESLOT) begin
                  st_in = STAT_RANGE;
               end
               state_in = S_RESP;
            end else begin
               state_in = S_REF_WAIT;
            end
         end
         S_POP_WAIT: begin
            page_in   = stk_rdata;
            rc_in     = COUNT_W'(1);
            ref_we    = 1'b1;
            ref_waddr = pop_pa;
            ref_wdata = COUNT_W'(1);
            state_in  = S_WIPE;
         end
         S_WIPE: begin
            sh_we    = 1'b1;
            sh_waddr = {pa, iss_ff[SLOT_AW-1:0]};
            iss_in   = iss_ff + SCNT_W'(1);
            if (iss_ff[SLOT_AW-1:0] == LAST_SLOT) begin
               state_in = S_RESP;
            end
         end
         S_REF_WAIT: begin
            rc_in    = ref_rdata;
            state_in = S_RESP;
            case (mode_ff)
               MODE_FREE: begin
                  nc        = (ref_rdata != '0) ? ref_rdata - COUNT_W'(1) : '0;
                  rc_in     = nc;
                  ref_we    = 1'b1;
                  ref_wdata = nc;
                  if (nc == '0) begin
                     if (fcnt_ff == FCNT_W'(NUM_PAGES)) begin
                        st_in = STAT_OVERFLOW;
                     end else begin
                        stk_we  = 1'b1;
                        fcnt_in = fcnt_ff + FCNT_W'(1);
                     end
                  end
               end
               MODE_INCREF: begin
                  nc        = (ref_rdata != '1) ? ref_rdata + COUNT_W'(1) : ref_rdata;
                  rc_in     = nc;
                  ref_we    = 1'b1;
                  ref_wdata = nc;
               end
               MODE_SETREF: begin
                  rc_in     = cval_ff;
                  ref_we    = 1'b1;
                  ref_wdata = cval_ff;
               end
               MODE_ADDSHR, MODE_REMOVESHR: begin
                  state_in = S_SCAN;
               end
               MODE_READSLOT: begin
                  if (slot_ok) begin
                     sh_raddr = {pa, slot_ff[SLOT_AW-1:0]};
                     state_in = S_SLOT_WAIT;
                  end else begin
                     st_in = STAT_RANGE;
                  end
               end
               MODE_WRITESLOT: begin
                  if (slot_ok) begin
                     sh_we    = 1'b1;
                     sh_waddr = {pa, slot_ff[SLOT_AW-1:0]};
                     sh_wdata = tag_ff;
                  end else begin
                     st_in = STAT_RANGE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            // issue one slot read per cycle, check the slot read the cycle before
            if (iss_ff != SCNT_W'(SHARERS)) begin
               iss_in  = iss_ff + SCNT_W'(1);
               dv_in   = 1'b1;
               didx_in = iss_ff[SLOT_AW-1:0];
            end
            if (dv_ff) begin
               if (mode_ff == MODE_ADDSHR) begin
                  if (!found_ff && sh_rdata == '0) begin
                     found_in = 1'b1;
                     at_in    = didx_ff;
                  end
                  if (sh_rdata == tag_ff) begin
                     present_in = 1'b1;
                  end
               end else if (sh_rdata == tag_ff) begin
                  sh_we = 1'b1;
               end
               if (didx_ff == LAST_SLOT) begin
                  state_in = (mode_ff == MODE_ADDSHR) ? S_ADD_FIN : S_RESP;
               end
            end
         end
         S_ADD_FIN: begin
            if (!present_ff) begin
               if (found_ff) begin
                  sh_we    = 1'b1;
                  sh_waddr = {pa, at_ff};
                  sh_wdata = tag_ff;
               end else begin
                  st_in = STAT_FULL;
               end
            end
            state_in = S_RESP;
         end
         S_SLOT_WAIT: begin
            sout_in  = sh_rdata;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sout_ff, fcnt_ext[FREE_W-1:0], rc_ff, page_ff, st_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         fcnt_ff      <= '0;
         first_ff     <= '0;
         clr_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fcnt_ff      <= fcnt_in;
         first_ff     <= first_in;
         clr_ff       <= clr_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      page_ff     <= page_in;
      cval_ff     <= cval_in;
      tag_ff      <= tag_in;
      slot_ff     <= slot_in;
      st_ff       <= st_in;
      rc_ff       <= rc_in;
      sout_ff     <= sout_in;
      iss_ff      <= iss_in;
      didx_ff     <= didx_in;
      found_ff    <= found_in;
      present_ff  <= present_in;
      at_ff       <= at_in;
      rsp_data_ff <= rsp_data_in;
   end

   rpa_ram #(.WIDTH(PAGE_W), .AW(PAGE_AW)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   rpa_ram #(.WIDTH(COUNT_W), .AW(PAGE_AW)) u_counts (
      .clock (clock),
      .we    (ref_we),
      .waddr (ref_waddr),
      .wdata (ref_wdata),
      .raddr (ref_raddr),
      .rdata (ref_rdata)
   );

   rpa_ram #(.WIDTH(TAG_W), .AW(SH_AW)) u_sharers (
      .clock (clock),
      .we    (sh_we),
      .waddr (sh_waddr),
      .wdata (sh_wdata),
      .raddr (sh_raddr),
      .rdata (sh_rdata)
   );

endmodule

### rtl/rpa_ram.sv
// Single-write, single-read synchronous memory with registered read data.
module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [2**AW];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sim/page_alloc_checker.sv
// Checker for the page allocator: watches all channels, predicts each result and compares.
`timescale 1ns / 100ps
module page_alloc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [9:0]  csr_data,
   output int          pending,
   output int          fails,
   output int          rsp_seen
);
   import rpa_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [PAGE_W-1:0]  page_out;
      logic [COUNT_W-1:0] ref_count;
      logic [FREE_W-1:0]  free_pages;
      logic [TAG_W-1:0]   sharer_out;
   } page_rsp_type;

   logic [PAGE_W-1:0]  free_stack_mdl [0:NUM_PAGES_DEF-1];
   int unsigned        stack_depth;
   logic [COUNT_W-1:0] page_refs [0:NUM_PAGES_DEF-1];
   logic [TAG_W-1:0]   sharer_tab [0:NUM_PAGES_DEF*SHARERS_DEF-1];
   logic [PAGE_W-1:0]  low_page;
   page_rsp_type       rsp_expected [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fails++;
   endtask

   task automatic predict_command(input logic [63:0] d);
      logic [MODE_W-1:0]  mode;
      logic [PAGE_W-1:0]  pg;
      logic [PAGE_W-1:0]  popped;
      logic [COUNT_W-1:0] cval;
      logic [TAG_W-1:0]   tag;
      logic [SLOT_W-1:0]  sl;
      page_rsp_type       r;
      int                 base;
      int                 at;
      bit                 present;
      bit                 found;
      bit                 in_range;
      mode     = d[3:0];
      pg       = d[13:4];
      cval     = d[21:14];
      tag      = d[53:22];
      sl       = d[59:54];
      r        = '0;
      r.page_out = pg;
      in_range = (pg >= low_page) && (int'(pg) < NUM_PAGES_DEF);
      base     = int'(pg) * SHARERS_DEF;
      if (mode == MODE_ALLOC) begin
         if (stack_depth == 0) begin
            r.status   = STAT_EMPTY;
            r.page_out = '0;
         end else begin
            stack_depth--;
            popped = free_stack_mdl[stack_depth];
            page_refs[popped] = COUNT_W'(1);
            for (int i = 0; i < SHARERS_DEF; i++)
               sharer_tab[int'(popped) * SHARERS_DEF + i] = '0;
            r.page_out  = popped;
            r.ref_count = COUNT_W'(1);
         end
      end else if (mode <= MODE_WRITESLOT && !in_range) begin
         r.status = STAT_RANGE;
      end else if (mode <= MODE_WRITESLOT) begin
         case (mode)
            MODE_FREE: begin
               if (page_refs[pg] > 0)
                  page_refs[pg]--;
               if (page_refs[pg] == 0) begin
                  if (stack_depth >= NUM_PAGES_DEF) begin
                     r.status = STAT_OVERFLOW;
                  end else begin
                     free_stack_mdl[stack_depth] = pg;
                     stack_depth++;
                  end
               end
            end
            MODE_INCREF: begin
               if (page_refs[pg] != 8'hFF)
                  page_refs[pg]++;
            end
            MODE_SETREF: page_refs[pg] = cval;
            MODE_ADDSHR: begin
               present = 0;
               found   = 0;
               at      = 0;
               for (int i = 0; i < SHARERS_DEF; i++) begin
                  if (!found && sharer_tab[base + i] == '0) begin
                     found = 1;
                     at    = i;
                  end
                  if (sharer_tab[base + i] == tag)
                     present = 1;
               end
               if (!present) begin
                  if (found)
                     sharer_tab[base + at] = tag;
                  else
                     r.status = STAT_FULL;
               end
            end
            MODE_REMOVESHR: begin
               for (int i = 0; i < SHARERS_DEF; i++)
                  if (sharer_tab[base + i] == tag)
                     sharer_tab[base + i] = '0;
            end
            MODE_READSLOT: begin
               if (sl < SHARERS_DEF)
                  r.sharer_out = sharer_tab[base + int'(sl)];
               else
                  r.status = STAT_RANGE;
            end
            MODE_WRITESLOT: begin
               if (sl < SHARERS_DEF)
                  sharer_tab[base + int'(sl)] = tag;
               else
                  r.status = STAT_RANGE;
            end
            default: ;
         endcase
         r.ref_count = page_refs[pg];
      end else if (in_range) begin
         r.ref_count = page_refs[pg];
      end
      r.free_pages = stack_depth[FREE_W-1:0];
      rsp_expected.push_back(r);
   endtask

   always @(posedge clock) begin
      page_rsp_type want;
      if (reset) begin
         fails       = 0;
         rsp_seen    = 0;
         stack_depth = 0;
         low_page    = '0;
         rsp_expected.delete();
         foreach (page_refs[i])
            page_refs[i] = '0;
         foreach (sharer_tab[i])
            sharer_tab[i] = '0;
      end else begin
         // compare first: a result at this edge belongs to an older item
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (rsp_expected.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata, 64'd0);
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_tdata[2:0] != want.status)
                  report_mismatch("status", rsp_tdata[2:0], want.status);
               if (rsp_tdata[12:3] != want.page_out)
                  report_mismatch("page_out", rsp_tdata[12:3], want.page_out);
               if (rsp_tdata[20:13] != want.ref_count)
                  report_mismatch("ref_count", rsp_tdata[20:13], want.ref_count);
               if (rsp_tdata[31:21] != want.free_pages)
                  report_mismatch("free_pages", rsp_tdata[31:21], want.free_pages);
               if (rsp_tdata[63:32] != want.sharer_out)
                  report_mismatch("sharer_out", rsp_tdata[63:32], want.sharer_out);
            end
         end
         if (req_tvalid && req_tready)
            predict_command(req_tdata);
         if (csr_valid && csr_ready)
            low_page = csr_data;
      end
      pending = rsp_expected.size();
   end

endmodule

### sim/refcounted_page_allocator_unit_test.sv
// Testbench top for the page allocator: clock, reset, stimulus, and verdict.
`timescale 1ns / 100ps
module refcounted_page_allocator_unit_test;
   import rpa_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 4'd9;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE      = 100;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [9:0]  csr_data;

   int          pending;
   int          fails;
   int          rsp_seen;
   int          cycles;
   int          idle_pct;
   int          sent;
   int          overflows;
   logic [9:0]  low_page;

   refcounted_page_allocator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   page_alloc_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .pending    (pending),
      .fails      (fails),
      .rsp_seen   (rsp_seen)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("TB_ERROR");
         $finish;
      end
   end

   // stall the result side at random
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= idle_pct);

   task automatic send_command(input logic [MODE_W-1:0] mode, input logic [9:0] pg,
                               input logic [7:0] cval, input logic [31:0] tag,
                               input logic [5:0] sl);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, sl, tag, cval, pg, mode};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      // let the checker see the last item taken before the count is read
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_low_page(input logic [9:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      low_page = value;
   endtask

   task automatic random_commands(input int count);
      logic [MODE_W-1:0] mode;
      logic [9:0]        pg;
      logic [7:0]        cval;
      logic [31:0]       tag;
      int                pick;
      for (int n = 0; n < count; n++) begin
         // a long stretch without idling in the middle of each batch
         idle_pct = (n > count / 3 && n < count / 2) ? 0 : 8;
         pick = $urandom_range(99);
         if (pick < 14)      mode = MODE_ALLOC;
         else if (pick < 28) mode = MODE_FREE;
         else if (pick < 36) mode = MODE_INCREF;
         else if (pick < 43) mode = MODE_SETREF;
         else if (pick < 48) mode = MODE_READREF;
         else if (pick < 66) mode = MODE_ADDSHR;
         else if (pick < 74) mode = MODE_REMOVESHR;
         else if (pick < 84) mode = MODE_READSLOT;
         else if (pick < 95) mode = MODE_WRITESLOT;
         else                mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         pick = $urandom_range(99);
         if (pick < 50)
            pg = (low_page > 10'd1019) ? 10'd1023 : low_page + 10'($urandom_range(3));
         else if (pick < 85)
            pg = 10'($urandom_range(low_page, 1023));
         else
            pg = 10'($urandom_range(1023));
         pick = $urandom_range(99);
         if (pick < 10)      cval = 8'hFF;
         else if (pick < 20) cval = 8'($urandom_range(2));
         else                cval = 8'($urandom_range(255));
         pick = $urandom_range(99);
         if (pick < 55)      tag = 32'($urandom_range(200));
         else if (pick < 60) tag = 32'hFFFF_FFFF;
         else                tag = 32'($urandom);
         send_command(mode, pg, cval, tag, 6'($urandom_range(63)));
      end
   endtask

   initial begin
      cycles     = 0;
      sent       = 0;
      idle_pct   = 8;
      low_page   = '0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty stack, seeding, saturation, sharer corner cases
      send_command(MODE_ALLOC, 10'd0, 8'd0, 32'd0, 6'd0);
      send_command(MODE_READREF, 10'd0, 8'd0, 32'd0, 6'd0);
      send_command(MODE_FREE, 10'd5, 8'd0, 32'd0, 6'd0);
      send_command(MODE_FREE, 10'd1023, 8'd0, 32'd0, 6'd0);
      send_command(MODE_FREE, 10'd0, 8'd0, 32'd0, 6'd0);
      send_command(MODE_ALLOC, 10'd1023, 8'd0, 32'd0, 6'd0);
      send_command(MODE_ALLOC, 10'd0, 8'd0, 32'd0, 6'd0);
      send_command(MODE_SETREF, 10'd1023, 8'hFF, 32'd0, 6'd0);
      send_command(MODE_INCREF, 10'd1023, 8'd0, 32'd0, 6'd0);
      send_command(MODE_ADDSHR, 10'd1023, 8'd0, 32'hFFFF_FFFF, 6'd0);
      send_command(MODE_ADDSHR, 10'd1023, 8'd0, 32'hFFFF_FFFF, 6'd0);
      send_command(MODE_ADDSHR, 10'd1023, 8'd0, 32'd0, 6'd0);
      send_command(MODE_WRITESLOT, 10'd1023, 8'd0, 32'h1234_5678, 6'd63);
      send_command(MODE_READSLOT, 10'd1023, 8'd0, 32'd0, 6'd63);
      send_command(MODE_REMOVESHR, 10'd1023, 8'd0, 32'hFFFF_FFFF, 6'd0);
      send_command(MODE_READSLOT, 10'd1023, 8'd0, 32'd0, 6'd0);
      send_command(MODE_FREE, 10'd1023, 8'd0, 32'd0, 6'd0);
      send_command(MODE_SPARE_LO, 10'd5, 8'd0, 32'd0, 6'd0);
      send_command(MODE_SPARE_HI, 10'd1023, 8'd0, 32'd0, 6'd0);
      send_command(MODE_SETREF, 10'd5, 8'd0, 32'd0, 6'd0);
      set_low_page(10'd1023);
      send_command(MODE_READREF, 10'd0, 8'd0, 32'd0, 6'd0);
      send_command(MODE_FREE, 10'd1022, 8'd0, 32'd0, 6'd0);
      send_command(MODE_ALLOC, 10'd0, 8'd0, 32'd0, 6'd0);
      send_command(MODE_SPARE_HI, 10'd0, 8'd0, 32'd0, 6'd0);

      random_commands(60);
      set_low_page(10'($urandom_range(1, 1022)));
      random_commands(90);
      set_low_page(10'd0);
      random_commands(60);
      drain_results();
      random_commands(40);

      // fill the free stack past its depth by freeing an idle page over and over
      set_low_page(10'd0);
      idle_pct = 0;
      send_command(MODE_SETREF, 10'd7, 8'd0, 32'd0, 6'd0);
      overflows = NUM_PAGES_DEF + 4;
      for (int n = 0; n < overflows; n++)
         send_command(MODE_FREE, 10'd7, 8'd0, 32'd0, 6'd0);
      random_commands(50);

      drain_results();
      $display("sent %0d commands, checked %0d results, %0d mismatches",
               sent, rsp_seen, fails);
      $display("covered all modes, three first_page settings and a full free stack");
      if (fails == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
